// ===== rtl/mgxh_pkg.sv =====
// ----------------------------------------------------------------------------
// mgxh_pkg: shared types and constants for the masked-gather XOR matrix hash
// Register indexes, request operations, matrix geometry and row reset values.
// ----------------------------------------------------------------------------
package mgxh_pkg;

   // Key and matrix geometry
   localparam int KEY_BITS   = 64;
   localparam int ROW_COUNT  = 64;
   localparam int ROW_BITS   = 64;
   localparam int ROW_IDX_W  = $clog2(ROW_COUNT);
   localparam int PC_BITS    = 64;
   localparam int INSN_BITS  = 32;
   localparam int SRC_BITS   = PC_BITS + INSN_BITS;
   localparam int POS_W      = $clog2(SRC_BITS + 1);
   localparam int OUTW_W     = 7;
   localparam int SIB_W      = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   // Reset values of the control registers
   localparam logic [OUTW_W-1:0] OUT_BITS_RESET  = 7'd4;
   localparam logic              HASH_MODE_RESET = 1'b1;

   // Matrix rows that are not zero after reset
   localparam logic [ROW_BITS-1:0] ROW_RESET_A = 64'h6FFF_FFFF_FFFF_FFFF;
   localparam logic [ROW_BITS-1:0] ROW_RESET_B = 64'hAFFF_FFFF_FFFF_FFFF;
   localparam logic [ROW_BITS-1:0] ROW_RESET_C = 64'h4FFF_FFFF_FFFF_FFFF;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PC_MASK   = 3'd0,
      CSR_IWORD_SEL = 3'd1,
      CSR_OUT_BITS  = 3'd2,
      CSR_HASH_MODE = 3'd3,
      CSR_SET_BITS  = 3'd4
   } csr_index_type;

   // Request operations
   typedef enum logic {
      OP_HASH      = 1'b0,
      OP_WRITE_ROW = 1'b1
   } op_type;

   // Hash modes
   typedef enum logic {
      MODE_TRUNCATE = 1'b0,
      MODE_MATRIX   = 1'b1
   } mode_type;

   // Selection masks handed to the gather unit
   typedef struct packed {
      logic [PC_BITS-1:0]   pc_mask;
      logic [INSN_BITS-1:0] iword_sel;
   } select_type;

   // One matrix row write
   typedef struct packed {
      logic                 enable;
      logic [ROW_IDX_W-1:0] index;
      logic [ROW_BITS-1:0]  value;
   } row_write_type;

   // Contents of a matrix row straight after reset
   function automatic logic [ROW_BITS-1:0] row_reset_value(input logic [ROW_IDX_W-1:0] idx);
      logic [ROW_BITS-1:0] val;
      val = '0;
      if (idx == ROW_IDX_W'(0) || idx == ROW_IDX_W'(3)) begin
         val = ROW_RESET_A;
      end else if (idx == ROW_IDX_W'(1)) begin
         val = ROW_RESET_B;
      end else if (idx == ROW_IDX_W'(2)) begin
         val = ROW_RESET_C;
      end
      return val;
   endfunction

endpackage

// ===== rtl/mgxh_gather.sv =====
// ----------------------------------------------------------------------------
// mgxh_gather: masked bit gather
// Packs the selected pc bits, then the selected instruction bits, densely
// into a 64-bit key. Source positions are precomputed from the masks.
// ----------------------------------------------------------------------------
module mgxh_gather (
   input  logic                                clock,
   input  mgxh_pkg::select_type                sel,
   input  logic [mgxh_pkg::PC_BITS-1:0]        pc,
   input  logic [mgxh_pkg::INSN_BITS-1:0]      insn,
   output logic [mgxh_pkg::KEY_BITS-1:0]       key
);

   logic [mgxh_pkg::SRC_BITS-1:0] src_mask;
   logic [mgxh_pkg::SRC_BITS-1:0] src_data;
   logic [mgxh_pkg::POS_W-1:0]    pos_ff [mgxh_pkg::SRC_BITS];
   logic [mgxh_pkg::POS_W-1:0]    pos_in [mgxh_pkg::SRC_BITS];

   // insn bits sit above pc bits, so one prefix count covers both
   assign src_mask = {sel.iword_sel, sel.pc_mask};
   assign src_data = {insn, pc};

   // key position of every source bit: number of selected bits below it
   always_comb begin
      for (int b = 0; b < mgxh_pkg::SRC_BITS; b++) begin
         pos_in[b] = mgxh_pkg::POS_W'($countones(src_mask &
                     ((mgxh_pkg::SRC_BITS'(1) << b) - mgxh_pkg::SRC_BITS'(1))));
      end
   end

   // user must change masks only while idle (unenforced): positions then settle
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   // crossbar: each key bit takes the selected source bit landing on it;
   // positions past the key top are dropped
   always_comb begin
      key = '0;
      for (int k = 0; k < mgxh_pkg::KEY_BITS; k++) begin
         for (int b = 0; b < mgxh_pkg::SRC_BITS; b++) begin
            if (src_mask[b] && pos_ff[b] == mgxh_pkg::POS_W'(k)) begin
               key[k] = key[k] | src_data[b];
            end
         end
      end
   end

endmodule

// ===== rtl/mgxh_matrix.sv =====
// ----------------------------------------------------------------------------
// mgxh_matrix: hash matrix rows and XOR reduction
// 64 rows of 64 bits in flip-flops, one row written per cycle; the XOR of
// all rows selected by the key bits is formed in one pass.
// ----------------------------------------------------------------------------
module mgxh_matrix (
   input  logic                             clock,
   input  logic                             reset,
   input  mgxh_pkg::row_write_type          wr,
   input  logic [mgxh_pkg::KEY_BITS-1:0]    key,
   output logic [mgxh_pkg::ROW_BITS-1:0]    xor_out
);

   logic [mgxh_pkg::ROW_BITS-1:0] rows_ff [mgxh_pkg::ROW_COUNT];

   // row storage with fixed reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mgxh_pkg::ROW_COUNT; i++) begin
            rows_ff[i] <= mgxh_pkg::row_reset_value(mgxh_pkg::ROW_IDX_W'(i));
         end
      end else if (wr.enable) begin
         rows_ff[wr.index] <= wr.value;
      end
   end

   // XOR of the rows picked by set key bits
   always_comb begin
      xor_out = '0;
      for (int i = 0; i < mgxh_pkg::KEY_BITS && i < mgxh_pkg::ROW_COUNT; i++) begin
         if (key[i]) begin
            xor_out = xor_out ^ rows_ff[i];
         end
      end
   end

endmodule

// ===== rtl/masked_gather_xor_matrix_hash_unit.sv =====
// ----------------------------------------------------------------------------
// masked_gather_xor_matrix_hash_unit: masked-gather XOR matrix hash
// Pipeline: a hash request passes the request, key and result registers.
// Throughput: one request per cycle while rsp_stall does not hold it back;
//   the gather crossbar and the row XOR each take one stage. Row writes
//   finish in the key stage and give no result.
// Reset: synchronous; control registers take their reset values and matrix
//   rows 0 to 3 load fixed constants, the rest clear to zero.
// ----------------------------------------------------------------------------
module masked_gather_xor_matrix_hash_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [mgxh_pkg::PC_BITS-1:0]         req_pc,
   input  logic [mgxh_pkg::INSN_BITS-1:0]       req_insn,
   input  logic [mgxh_pkg::ROW_IDX_W-1:0]       req_row_index,
   input  logic [mgxh_pkg::ROW_BITS-1:0]        req_row_value,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [63:0]                          rsp_hash_value,
   output logic [63:0]                          rsp_set_index,
   output logic [63:0]                          rsp_tag,
   // configuration write port
   input  logic                                 csr_write_enable,
   input  logic [mgxh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mgxh_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   // configuration registers
   logic [mgxh_pkg::PC_BITS-1:0]   pc_mask_ff;
   logic [mgxh_pkg::INSN_BITS-1:0] iword_sel_ff;
   logic [mgxh_pkg::OUTW_W-1:0]    out_bits_ff;
   mgxh_pkg::mode_type             mode_ff;
   logic [mgxh_pkg::SIB_W-1:0]     set_bits_ff;

   // request stage
   logic                           a_valid_ff;
   mgxh_pkg::op_type               a_op_ff;
   logic [mgxh_pkg::PC_BITS-1:0]   a_pc_ff;
   logic [mgxh_pkg::INSN_BITS-1:0] a_insn_ff;
   logic [mgxh_pkg::ROW_IDX_W-1:0] a_row_idx_ff;
   logic [mgxh_pkg::ROW_BITS-1:0]  a_row_val_ff;

   // key stage
   logic                           b_valid_ff;
   logic                           b_valid_in;
   mgxh_pkg::op_type               b_op_ff;
   logic [mgxh_pkg::KEY_BITS-1:0]  b_key_ff;
   logic [mgxh_pkg::KEY_BITS-1:0]  b_key_in;
   logic [mgxh_pkg::ROW_IDX_W-1:0] b_row_idx_ff;
   logic [mgxh_pkg::ROW_BITS-1:0]  b_row_val_ff;

   // result stage
   logic                           r_valid_ff;
   logic                           r_valid_in;
   logic [63:0]                    r_hash_ff;
   logic [63:0]                    r_set_ff;
   logic [63:0]                    r_tag_ff;
   logic [63:0]                    hash_in;
   logic [63:0]                    set_in;
   logic [63:0]                    tag_in;

   // handshake and stage movement
   logic                           req_take;
   logic                           rsp_take;
   logic                           r_free;
   logic                           b_move;
   logic                           b_free;
   logic                           a_move;
   logic                           a_free;
   logic [mgxh_pkg::OUTW_W-1:0]    width;
   logic [mgxh_pkg::ROW_BITS-1:0]  xor_val;
   mgxh_pkg::select_type           sel;
   mgxh_pkg::row_write_type        row_wr;

   // configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_mask_ff   <= '0;
         iword_sel_ff <= '0;
         out_bits_ff  <= mgxh_pkg::OUT_BITS_RESET;
         mode_ff      <= mgxh_pkg::mode_type'(mgxh_pkg::HASH_MODE_RESET);
         set_bits_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (mgxh_pkg::csr_index_type'(csr_index))
            mgxh_pkg::CSR_PC_MASK: begin
               pc_mask_ff <= csr_write_data;
            end
            mgxh_pkg::CSR_IWORD_SEL: begin
               iword_sel_ff <= csr_write_data[mgxh_pkg::INSN_BITS-1:0];
            end
            mgxh_pkg::CSR_OUT_BITS: begin
               out_bits_ff <= csr_write_data[mgxh_pkg::OUTW_W-1:0];
            end
            mgxh_pkg::CSR_HASH_MODE: begin
               mode_ff <= mgxh_pkg::mode_type'(csr_write_data[0]);
            end
            mgxh_pkg::CSR_SET_BITS: begin
               set_bits_ff <= csr_write_data[mgxh_pkg::SIB_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline flow: row writes retire in the key stage, hashes move on
   assign rsp_take = r_valid_ff && !rsp_stall;
   assign r_free   = !r_valid_ff || !rsp_stall;
   assign b_move   = b_valid_ff && (b_op_ff == mgxh_pkg::OP_WRITE_ROW || r_free);
   assign b_free   = !b_valid_ff || b_move;
   assign a_move   = a_valid_ff && b_free;
   assign a_free   = !a_valid_ff || a_move;
   assign req_stall = !a_free;
   assign req_take  = req_valid && a_free;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_free) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_op_ff      <= mgxh_pkg::op_type'(req_operation);
         a_pc_ff      <= req_pc;
         a_insn_ff    <= req_insn;
         a_row_idx_ff <= req_row_index;
         a_row_val_ff <= req_row_value;
      end
   end

   // gather the key from the request register
   assign sel.pc_mask   = pc_mask_ff;
   assign sel.iword_sel = iword_sel_ff;

   mgxh_gather u_gather (
      .clock (clock),
      .sel   (sel),
      .pc    (a_pc_ff),
      .insn  (a_insn_ff),
      .key   (b_key_in)
   );

   // key register
   always_comb begin
      b_valid_in = b_valid_ff;
      if (b_free) begin
         b_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_op_ff      <= a_op_ff;
         b_key_ff     <= b_key_in;
         b_row_idx_ff <= a_row_idx_ff;
         b_row_val_ff <= a_row_val_ff;
      end
   end

   // row writes land in program order with the hashes that read the rows
   assign row_wr.enable = b_move && b_op_ff == mgxh_pkg::OP_WRITE_ROW;
   assign row_wr.index  = b_row_idx_ff;
   assign row_wr.value  = b_row_val_ff;

   mgxh_matrix u_matrix (
      .clock   (clock),
      .reset   (reset),
      .wr      (row_wr),
      .key     (b_key_ff),
      .xor_out (xor_val)
   );

   // hash width clamped to 64, then truncate or keep the top bits
   assign width = (out_bits_ff > mgxh_pkg::OUTW_W'(64)) ? mgxh_pkg::OUTW_W'(64) : out_bits_ff;

   always_comb begin
      hash_in = '0;
      if (width == '0) begin
         hash_in = '0;
      end else if (mode_ff == mgxh_pkg::MODE_TRUNCATE) begin
         if (width == mgxh_pkg::OUTW_W'(64)) begin
            hash_in = b_key_ff;
         end else begin
            hash_in = b_key_ff & ~({64{1'b1}} << width[5:0]);
         end
      end else begin
         if (width == mgxh_pkg::OUTW_W'(64)) begin
            hash_in = xor_val;
         end else begin
            hash_in = xor_val >> (mgxh_pkg::OUTW_W'(64) - width);
         end
      end
      // split into set index and tag
      set_in = hash_in & ~({64{1'b1}} << set_bits_ff);
      tag_in = hash_in >> set_bits_ff;
   end

   // result register
   always_comb begin
      r_valid_in = r_valid_ff;
      if (b_move && b_op_ff == mgxh_pkg::OP_HASH) begin
         r_valid_in = 1'b1;
      end else if (rsp_take) begin
         r_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= r_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_move && b_op_ff == mgxh_pkg::OP_HASH) begin
         r_hash_ff <= hash_in;
         r_set_ff  <= set_in;
         r_tag_ff  <= tag_in;
      end
   end

   assign rsp_valid      = r_valid_ff;
   assign rsp_hash_value = r_hash_ff;
   assign rsp_set_index  = r_set_ff;
   assign rsp_tag        = r_tag_ff;

endmodule
